/* rtl/mse_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mse_pkg
// Shared widths, default capacity and sequencer state codes for the merge
// sort engine.
// ----------------------------------------------------------------------------
package mse_pkg;

    localparam int DATA_W        = 32;
    localparam int MAX_ITEMS_DEF = 64;

    localparam int STATE_W = 3;

    localparam logic [STATE_W-1:0] S_IDLE       = 3'd0;
    localparam logic [STATE_W-1:0] S_SETUP      = 3'd1;
    localparam logic [STATE_W-1:0] S_PRIME      = 3'd2;
    localparam logic [STATE_W-1:0] S_MERGE      = 3'd3;
    localparam logic [STATE_W-1:0] S_EMIT_PRIME = 3'd4;
    localparam logic [STATE_W-1:0] S_EMIT       = 3'd5;

endpackage

/* rtl/merge_sort_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// merge_sort_engine
// Stable ascending sort of a set of signed values by bottom-up merging
// between two RAMs that swap roles on every pass.
// ----------------------------------------------------------------------------
//  Channel   Signals                               Handshake
//  request   in_value, in_last                     start & !busy
//  result    out_value, out_last, overflow         out_valid, one cycle
//
//  A request without in_last is stored, or dropped once the set is full, and
//  the engine stays idle. After the request with in_last, busy stays high for
//  a set of n elements through P = ceil(log2 n) merge passes of one element
//  per cycle each. Results then come on consecutive cycles, the last one in
//  the first cycle with busy low. Reset clears the sequencer, the element count
//  and the dropped flag, but not the overflow output. The receiver cannot stall.
// ----------------------------------------------------------------------------
module merge_sort_engine #(
    parameter int MAX_ITEMS = mse_pkg::MAX_ITEMS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [mse_pkg::DATA_W-1:0]  in_value,
    input  logic                               in_last,
    output logic                               out_valid,
    output logic signed [mse_pkg::DATA_W-1:0]  out_value,
    output logic                               out_last,
    output logic                               overflow
);

    import mse_pkg::*;

    localparam int ADDR_W = $clog2(MAX_ITEMS);
    localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
    localparam int EXT_W  = CNT_W + 2;

    logic [STATE_W-1:0] state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               dropped_reg, dropped_next;
    logic               src_reg, src_next;
    logic [CNT_W-1:0]   width_reg, width_next;
    logic [CNT_W-1:0]   a_reg, a_next;
    logic [CNT_W-1:0]   b_reg, b_next;
    logic [CNT_W-1:0]   mid_reg, mid_next;
    logic [CNT_W-1:0]   hi_reg, hi_next;
    logic [CNT_W-1:0]   d_reg, d_next;

    logic               out_valid_reg, out_valid_next;
    logic               out_last_reg, out_last_next;
    logic               overflow_reg, overflow_next;
    logic signed [DATA_W-1:0] out_value_reg, out_value_next;

    logic [DATA_W-1:0]  rd0_a, rd0_b, rd1_a, rd1_b;
    logic signed [DATA_W-1:0] sel_a, sel_b, merge_data;

    logic               load_we;
    logic               merge_we;
    logic               take_a;
    logic               seg_end;
    logic [EXT_W-1:0]   n_ext, hi_ext, w_ext, w2_ext;
    logic [EXT_W-1:0]   mid_sum, hi_sum, w4_ext;

    logic               ram0_we, ram1_we;
    logic [ADDR_W-1:0]  ram0_waddr;
    logic [DATA_W-1:0]  ram0_wdata;

    assign sel_a = src_reg ? rd1_a : rd0_a;
    assign sel_b = src_reg ? rd1_b : rd0_b;

    assign take_a     = (a_reg < mid_reg) && ((b_reg >= hi_reg) || (sel_a <= sel_b));
    assign merge_data = take_a ? sel_a : sel_b;
    assign seg_end    = ((d_reg + 1'b1) == hi_reg);

    assign n_ext   = EXT_W'(count_reg);
    assign hi_ext  = EXT_W'(hi_reg);
    assign w_ext   = EXT_W'(width_reg);
    assign w2_ext  = w_ext << 1;
    assign w4_ext  = w_ext << 2;
    assign mid_sum = hi_ext + w_ext;
    assign hi_sum  = hi_ext + w2_ext;

    assign load_we  = (state_reg == S_IDLE) && start && (count_reg < CNT_W'(MAX_ITEMS));
    assign merge_we = (state_reg == S_MERGE);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        dropped_next   = dropped_reg;
        src_next       = src_reg;
        width_next     = width_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        mid_next       = mid_reg;
        hi_next        = hi_reg;
        d_next         = d_reg;
        out_valid_next = 1'b0;
        out_last_next  = 1'b0;
        overflow_next  = dropped_reg;
        out_value_next = sel_a;

        case (state_reg)
            S_IDLE:
            begin
                src_next = 1'b0;
                if (start)
                begin
                    if (load_we)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                    if (in_last)
                    begin
                        state_next = S_SETUP;
                    end
                end
            end

            S_SETUP:
            begin
                width_next = CNT_W'(1);
                a_next     = '0;
                d_next     = '0;
                if (count_reg <= CNT_W'(1))
                begin
                    state_next = S_EMIT_PRIME;
                end
                else
                begin
                    mid_next   = CNT_W'(1);
                    b_next     = CNT_W'(1);
                    hi_next    = CNT_W'(2);
                    state_next = S_PRIME;
                end
            end

            S_PRIME:
            begin
                state_next = S_MERGE;
            end

            S_MERGE:
            begin
                d_next = d_reg + 1'b1;
                if (take_a)
                begin
                    a_next = a_reg + 1'b1;
                end
                else
                begin
                    b_next = b_reg + 1'b1;
                end
                if (seg_end)
                begin
                    if (hi_reg == count_reg)
                    begin
                        src_next = ~src_reg;
                        a_next   = '0;
                        d_next   = '0;
                        if (w2_ext >= n_ext)
                        begin
                            state_next = S_EMIT_PRIME;
                        end
                        else
                        begin
                            width_next = w2_ext[CNT_W-1:0];
                            mid_next   = w2_ext[CNT_W-1:0];
                            b_next     = w2_ext[CNT_W-1:0];
                            hi_next    = (w4_ext >= n_ext) ? count_reg : w4_ext[CNT_W-1:0];
                            state_next = S_PRIME;
                        end
                    end
                    else
                    begin
                        a_next   = hi_reg;
                        mid_next = (mid_sum >= n_ext) ? count_reg : mid_sum[CNT_W-1:0];
                        b_next   = (mid_sum >= n_ext) ? count_reg : mid_sum[CNT_W-1:0];
                        hi_next  = (hi_sum >= n_ext) ? count_reg : hi_sum[CNT_W-1:0];
                    end
                end
            end

            S_EMIT_PRIME:
            begin
                state_next = S_EMIT;
            end

            S_EMIT:
            begin
                out_valid_next = 1'b1;
                out_last_next  = ((a_reg + 1'b1) == count_reg);
                a_next         = a_reg + 1'b1;
                if ((a_reg + 1'b1) == count_reg)
                begin
                    count_next   = '0;
                    dropped_next = 1'b0;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            src_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dropped_reg   <= dropped_next;
            src_reg       <= src_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        width_reg     <= width_next;
        a_reg         <= a_next;
        b_reg         <= b_next;
        mid_reg       <= mid_next;
        hi_reg        <= hi_next;
        d_reg         <= d_next;
        out_last_reg  <= out_last_next;
        overflow_reg  <= overflow_next;
        out_value_reg <= out_value_next;
    end

    assign ram0_we    = load_we || (merge_we && src_reg);
    assign ram1_we    = merge_we && !src_reg;
    assign ram0_waddr = load_we ? count_reg[ADDR_W-1:0] : d_reg[ADDR_W-1:0];
    assign ram0_wdata = load_we ? in_value : merge_data;

    mse_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_ITEMS)
    ) u_ram0 (
        .clk     (clk),
        .we      (ram0_we),
        .waddr   (ram0_waddr),
        .wdata   (ram0_wdata),
        .raddr_a (a_next[ADDR_W-1:0]),
        .raddr_b (b_next[ADDR_W-1:0]),
        .rdata_a (rd0_a),
        .rdata_b (rd0_b)
    );

    mse_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_ITEMS)
    ) u_ram1 (
        .clk     (clk),
        .we      (ram1_we),
        .waddr   (d_reg[ADDR_W-1:0]),
        .wdata   (merge_data),
        .raddr_a (a_next[ADDR_W-1:0]),
        .raddr_b (b_next[ADDR_W-1:0]),
        .rdata_a (rd1_a),
        .rdata_b (rd1_b)
    );

    assign busy      = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign out_last  = out_last_reg;
    assign overflow  = overflow_reg;

endmodule

/* rtl/mse_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mse_ram
// Generic RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module mse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for merge_sort_engine. Sets of signed values are sent
// as requests and the expected ascending order, last mark and overflow flag
// of every set are predicted locally. Each strobed result is checked against
// the oldest prediction. Small random sets, full sets and sets that overrun
// the capacity are mixed, with random gaps between requests.
// ----------------------------------------------------------------------------

typedef struct {
    logic signed [mse_pkg::DATA_W-1:0] value;
    logic                              last;
    logic                              ovf;
} sorted_elem_t;

class sorted_set_tracker;

    logic signed [mse_pkg::DATA_W-1:0] held [mse_pkg::MAX_ITEMS_DEF];
    int unsigned                       held_count;
    bit                                dropped;
    sorted_elem_t                      sorted_expect [$];
    int unsigned                       mismatches;

    function new();
        held_count = 0;
        dropped    = 0;
        mismatches = 0;
    endfunction

    function void note_request(logic signed [mse_pkg::DATA_W-1:0] value, logic last);
        logic signed [mse_pkg::DATA_W-1:0] key;
        sorted_elem_t                      e;
        int                                i;
        int                                j;
        if (held_count < mse_pkg::MAX_ITEMS_DEF)
        begin
            held[held_count] = value;
            held_count++;
        end
        else
        begin
            dropped = 1'b1;
        end
        if (last)
        begin
            for (i = 1; i < held_count; i++)
            begin
                key = held[i];
                j   = i - 1;
                while (j >= 0 && held[j] > key)
                begin
                    held[j + 1] = held[j];
                    j--;
                end
                held[j + 1] = key;
            end
            for (i = 0; i < held_count; i++)
            begin
                e.value = held[i];
                e.last  = (i == held_count - 1);
                e.ovf   = dropped;
                sorted_expect.push_back(e);
            end
            held_count = 0;
            dropped    = 1'b0;
        end
    endfunction

    function void note_mismatch(string what, sorted_elem_t e,
                                logic signed [mse_pkg::DATA_W-1:0] value,
                                logic last, logic ovf);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("%0t: %s: expected value=%0d last=%0b overflow=%0b",
                     $time, what, e.value, e.last, e.ovf);
            $display("    got value=%0d last=%0b overflow=%0b", value, last, ovf);
        end
    endfunction

    function void check_result(logic signed [mse_pkg::DATA_W-1:0] value,
                               logic last, logic ovf);
        sorted_elem_t e;
        if (sorted_expect.size() == 0)
        begin
            e.value = 'x;
            e.last  = 1'bx;
            e.ovf   = 1'bx;
            note_mismatch("unexpected result", e, value, last, ovf);
            return;
        end
        e = sorted_expect.pop_front();
        if (e.value !== value || e.last !== last || e.ovf !== ovf)
            note_mismatch("result mismatch", e, value, last, ovf);
    endfunction

    function int pending();
        return sorted_expect.size();
    endfunction

endclass

module tb;

    import mse_pkg::*;

    localparam int          CAPACITY     = MAX_ITEMS_DEF;
    localparam int          RANDOM_ITEMS = 340;
    localparam int          SETTLE       = 20;
    localparam int unsigned CYCLE_LIMIT  = 400000;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic signed [DATA_W-1:0] in_value;
    logic                     in_last;
    logic                     out_valid;
    logic signed [DATA_W-1:0] out_value;
    logic                     out_last;
    logic                     overflow;

    sorted_set_tracker tracker = new();
    int unsigned       cycle_count = 0;
    bit                burst_mode = 1'b0;

    merge_sort_engine uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .in_value  (in_value),
        .in_last   (in_last),
        .out_valid (out_valid),
        .out_value (out_value),
        .out_last  (out_last),
        .overflow  (overflow)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid)
            tracker.check_result(out_value, out_last, overflow);
    end

    function automatic logic signed [DATA_W-1:0] pick_value();
        int unsigned mode;
        mode = $urandom_range(0, 9);
        if (mode <= 5)
            return $urandom;
        if (mode == 6)
        begin
            case ($urandom_range(0, 4))
                0:       return 32'sh8000_0000;
                1:       return 32'sh7FFF_FFFF;
                2:       return 32'sd0;
                3:       return -32'sd1;
                default: return 32'sd1;
            endcase
        end
        return int'($urandom_range(0, 8)) - 4;
    endfunction

    task automatic send_request(input logic signed [DATA_W-1:0] value, input logic last);
        start    <= 1'b1;
        in_value <= value;
        in_last  <= last;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        tracker.note_request(value, last);
    endtask

    task automatic idle_gap();
        int unsigned roll;
        int unsigned cycles;
        roll = $urandom_range(0, 99);
        if (burst_mode || roll < 40)
            cycles = 0;
        else if (roll < 85)
            cycles = $urandom_range(1, 3);
        else if (roll < 97)
            cycles = $urandom_range(4, 10);
        else
            cycles = $urandom_range(20, 60);
        if (cycles > 0)
        begin
            start <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    task automatic wait_results_done();
        start <= 1'b0;
        @(posedge clk);
        while (tracker.pending() != 0)
            @(posedge clk);
    endtask

    task automatic send_values(input logic signed [DATA_W-1:0] vals [$]);
        int i;
        for (i = 0; i < vals.size(); i++)
        begin
            send_request(vals[i], i == vals.size() - 1);
            idle_gap();
        end
    endtask

    task automatic send_random_set(input int set_size);
        int i;
        burst_mode = ($urandom_range(0, 3) == 0);
        for (i = 0; i < set_size; i++)
        begin
            send_request(pick_value(), i == set_size - 1);
            idle_gap();
        end
    endtask

    initial
    begin
        int          sent;
        int          set_size;
        int unsigned roll;

        rst_n    = 1'b0;
        start    = 1'b0;
        in_value = '0;
        in_last  = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        send_values('{32'sd42});
        send_values('{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0, -32'sd1, 32'sd1});
        send_values('{32'sd3, -32'sd3, 32'sd3, -32'sd3, 32'sd3, 32'sd0});
        send_values('{32'sd7, 32'sd6, 32'sd5, 32'sd4, 32'sd3, 32'sd2, 32'sd1, 32'sd0});
        send_values('{32'sh8000_0000, 32'sh8000_0000});

        wait_results_done();

        send_random_set(CAPACITY);
        send_random_set(CAPACITY + 2);
        sent = 2 * CAPACITY + 2;
        while (sent < RANDOM_ITEMS)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 60)
                set_size = $urandom_range(1, 8);
            else if (roll < 85)
                set_size = $urandom_range(9, 24);
            else if (roll < 93)
                set_size = CAPACITY;
            else
                set_size = $urandom_range(CAPACITY + 1, CAPACITY + 4);
            send_random_set(set_size);
            sent += set_size;
            if ($urandom_range(0, 7) == 0)
                wait_results_done();
        end

        wait_results_done();
        repeat (SETTLE) @(posedge clk);

        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

/* filelist.f */
rtl/mse_pkg.sv
rtl/mse_ram.sv
rtl/merge_sort_engine.sv
verif/tb.sv
